### design/tet_pkg.sv
// Package for the terminal escape tokenizer: character codes, token kinds,
// parser state encoding, result record and byte classifiers. No dependencies.
package tet_pkg;

	localparam logic [7:0] CH_ESC  = 8'h1B;
	localparam logic [7:0] CH_LBR  = 8'h5B;
	localparam logic [7:0] CH_RBR  = 8'h5D;
	localparam logic [7:0] CH_SEMI = 8'h3B;
	localparam logic [7:0] CH_M    = 8'h6D;
	localparam logic [7:0] CH_BEL  = 8'h07;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;
	localparam logic [7:0] CH_SP   = 8'h20;
	localparam logic [7:0] CH_TAB  = 8'h09;
	localparam logic [7:0] CH_CR   = 8'h0D;

	localparam logic [1:0] KIND_TEXT = 2'd0;
	localparam logic [1:0] KIND_SGR  = 2'd1;
	localparam logic [1:0] KIND_OSC  = 2'd2;
	localparam logic [1:0] KIND_UNK  = 2'd3;

	localparam logic REQ_DATA  = 1'b0;
	localparam logic REQ_FLUSH = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'd0,
		ST_TEXT  = 4'd1,
		ST_ESC   = 4'd2,
		ST_UNK   = 4'd3,
		ST_SGR_A = 4'd4,
		ST_SGR_B = 4'd5,
		ST_OSC_A = 4'd6,
		ST_OSC_B = 4'd7,
		ST_OSC_C = 4'd8
	} state_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       belongs;
		logic       starts_token;
		logic       ends_before;
		logic       ends_here;
		logic       end_ok;
		logic [1:0] end_kind;
	} res_t;

	function automatic logic is_ws(input logic [7:0] c);
		return (c == CH_SP) || (c >= CH_TAB && c <= CH_CR);
	endfunction

	function automatic logic is_dig(input logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	function automatic logic run_byte(input logic [7:0] c);
		return !c[7] && (c != CH_ESC);
	endfunction

endpackage

### design/terminal_escape_tokenizer_core.sv
// Top level of the terminal escape tokenizer: input register, parser state
// machine and result register. Depends on tet_pkg and tet_fsm.

// One byte (or an end-of-stream flush) per transfer goes in, and exactly one
// result per transfer comes out, in order, through the input and result
// registers. Without an output stall it sustains one transfer per cycle: the
// parser state register updates in the same cycle its byte moves into the
// result register, so the only loop is the 4-bit state decode. A stalled
// result holds in the result register while one more byte waits in the
// input register; further input is then stalled. Each result tells whether
// the byte belongs to a token, starts one, closes the previous token before
// it, or completes the current one (final 'm' of SGR, BEL of an OSC title),
// with the status and kind of any closed token. A flush closes any open
// token (an unfinished escape sequence closes with an error) and returns
// the parser to idle.
module terminal_escape_tokenizer_core import tet_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       req_type,
	input  logic [7:0] in_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       belongs,
	output logic       starts_token,
	output logic       ends_before,
	output logic       ends_here,
	output logic       end_ok,
	output logic [1:0] end_kind
);

	// input stage
	logic       valid_s1;
	logic       req_s1;
	logic [7:0] byte_s1;

	// result register
	logic       out_valid_q;
	res_t       res_q;
	res_t       res_d;

	logic       advance;

	// Advance the held byte whenever the result register is empty or drains.
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			req_s1  <= req_type;
			byte_s1 <= in_byte;
		end
	end

	tet_fsm u_fsm (
		.clk      (clk),
		.arst_n   (arst_n),
		.step_en  (advance),
		.req_type (req_s1),
		.in_byte  (byte_s1),
		.res      (res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Hold the result while stalled; load a new one on each advance.
	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_d;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_byte     = res_q.out_byte;
	assign belongs      = res_q.belongs;
	assign starts_token = res_q.starts_token;
	assign ends_before  = res_q.ends_before;
	assign ends_here    = res_q.ends_here;
	assign end_ok       = res_q.end_ok;
	assign end_kind     = res_q.end_kind;

`ifndef NO_ASSERTIONS
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid_q && out_stall))
		else $error("input stalled while pipeline can drain");

	a_ends_here_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && ends_here) |-> (end_ok && !ends_before && belongs))
		else $error("completed token without ok status");

	a_start_belongs: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && starts_token) |-> belongs)
		else $error("token start on a skipped byte");

	a_no_close_no_status: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !ends_before && !ends_here) |-> (!end_ok && end_kind == KIND_TEXT))
		else $error("status reported with no token closing");

	a_result_follows_byte: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("advanced byte produced no result");
`endif

endmodule

### design/tet_fsm.sv
// Parser state machine of the terminal escape tokenizer: state register and
// the per-byte decode that forms one result. Depends on tet_pkg.
module tet_fsm import tet_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step_en,
	input  logic       req_type,
	input  logic [7:0] in_byte,
	output res_t       res
);

	state_t state_q;
	state_t state_d;

	logic   c_ws;
	state_t idle_d;

	assign c_ws   = is_ws(in_byte);
	assign idle_d = c_ws ? ST_IDLE : ((in_byte == CH_ESC) ? ST_ESC : ST_TEXT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else if (step_en) begin
			state_q <= state_d;
		end
	end

	always_comb begin
		res     = '0;
		state_d = state_q;
		if (req_type == REQ_FLUSH) begin
			state_d = ST_IDLE;
			case (state_q)
				ST_TEXT: begin
					res.ends_before = 1'b1;
					res.end_ok      = 1'b1;
					res.end_kind    = KIND_TEXT;
				end
				ST_UNK: begin
					res.ends_before = 1'b1;
					res.end_ok      = 1'b1;
					res.end_kind    = KIND_UNK;
				end
				ST_ESC: begin
					res.ends_before = 1'b1;
					res.end_kind    = KIND_UNK;
				end
				ST_SGR_A, ST_SGR_B: begin
					res.ends_before = 1'b1;
					res.end_kind    = KIND_SGR;
				end
				ST_OSC_A, ST_OSC_B, ST_OSC_C: begin
					res.ends_before = 1'b1;
					res.end_kind    = KIND_OSC;
				end
				default: begin
				end
			endcase
		end else begin
			res.out_byte = in_byte;
			res.belongs  = 1'b1;
			case (state_q)
				ST_TEXT, ST_UNK: begin
					if (!run_byte(in_byte)) begin
						res.ends_before  = 1'b1;
						res.end_ok       = 1'b1;
						res.end_kind     = (state_q == ST_TEXT) ? KIND_TEXT : KIND_UNK;
						res.belongs      = !c_ws;
						res.starts_token = !c_ws;
						state_d          = idle_d;
					end
				end
				ST_ESC: begin
					if (in_byte == CH_LBR) begin
						state_d = ST_SGR_A;
					end else if (in_byte == CH_RBR) begin
						state_d = ST_OSC_A;
					end else begin
						state_d = ST_UNK;
					end
				end
				ST_SGR_A, ST_SGR_B: begin
					if (is_dig(in_byte)) begin
						state_d = state_q;
					end else if (in_byte == CH_M) begin
						res.ends_here = 1'b1;
						res.end_ok    = 1'b1;
						res.end_kind  = KIND_SGR;
						state_d       = ST_IDLE;
					end else if (in_byte == CH_SEMI && state_q == ST_SGR_A) begin
						state_d = ST_SGR_B;
					end else begin
						res.ends_before  = 1'b1;
						res.end_kind     = KIND_SGR;
						res.belongs      = !c_ws;
						res.starts_token = !c_ws;
						state_d          = idle_d;
					end
				end
				ST_OSC_A: begin
					if (in_byte == CH_ZERO) begin
						state_d = ST_OSC_B;
					end else begin
						res.ends_before  = 1'b1;
						res.end_kind     = KIND_OSC;
						res.belongs      = !c_ws;
						res.starts_token = !c_ws;
						state_d          = idle_d;
					end
				end
				ST_OSC_B: begin
					if (in_byte == CH_SEMI) begin
						state_d = ST_OSC_C;
					end else begin
						res.ends_before  = 1'b1;
						res.end_kind     = KIND_OSC;
						res.belongs      = !c_ws;
						res.starts_token = !c_ws;
						state_d          = idle_d;
					end
				end
				ST_OSC_C: begin
					if (in_byte == CH_BEL) begin
						res.ends_here = 1'b1;
						res.end_ok    = 1'b1;
						res.end_kind  = KIND_OSC;
						state_d       = ST_IDLE;
					end
				end
				default: begin
					res.belongs      = !c_ws;
					res.starts_token = !c_ws;
					state_d          = idle_d;
				end
			endcase
		end
	end

endmodule
